// File: rtl/dsr_pkg.sv
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared widths and constants for the binary64 to binary32 rounding pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package dsr_pkg;
	localparam int unsigned DATA_W = 64;
	localparam logic [31:0] F32_INF = 32'h7f80_0000;
	localparam logic [10:0] D64_EXP_MAX = 11'h7ff;
	localparam logic [63:0] D64_INF = 64'h7ff0_0000_0000_0000;
	localparam logic [10:0] EXP_BIAS_DIFF = 11'd896;
	localparam logic [10:0] SUB_BIAS = 11'd874;
endpackage
`default_nettype wire

// File: rtl/dsr_stream_if.sv
// ----------------------------------------------------------------------------
// dsr_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
`default_nettype none
interface dsr_stream_if #(parameter int unsigned W = 64);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/double_to_single_round_nearest.sv
// ----------------------------------------------------------------------------
// double_to_single_round_nearest
// Rounds a binary64 value to binary32 precision, round to nearest even, and
// returns the binary64 pattern of the rounded value.
// ----------------------------------------------------------------------------
// One request is accepted every cycle while the output is not stalled; each
// result passes through three register stages (decode and shift, round,
// repack with leading-one search), and a stall holds every stage in place.
// keep_double is sampled per request as it enters the first stage.
`default_nettype none
module double_to_single_round_nearest
	import dsr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	dsr_stream_if.sink cfg,
	dsr_stream_if.sink in_ch,
	dsr_stream_if.source out_ch
);
	logic keep_q;
	logic v_s1, v_s2, v_s3;
	logic adv;
	assign adv = !v_s3 || out_ch.ready;
	assign in_ch.ready = adv;
	assign cfg.ready = 1'b1;

	// stage 1 decode and align
	logic [63:0] x;
	logic [10:0] e;
	logic pass;
	logic [11:0] fe;
	logic [5:0] sh;
	logic zero_c, inf_c;
	logic [52:0] sig;
	logic [24:0] q_c;
	logic [54:0] low_c;
	logic grd_c, stk_c;
	assign x = in_ch.data;
	assign e = x[62:52];
	assign pass = keep_q || e == D64_EXP_MAX || x[62:0] == 63'd0;
	assign fe = {1'b0, e} - {1'b0, EXP_BIAS_DIFF};
	assign sig = {1'b1, x[51:0]};
	always_comb begin
		zero_c = 1'b0;
		inf_c = 1'b0;
		sh = 6'd29;
		if (e == 11'd0) zero_c = 1'b1;
		else if (!fe[11] && fe >= 12'd255) inf_c = 1'b1;
		else if (!fe[11] && fe != 12'd0) sh = 6'd29;
		else if ($signed(fe) < -12'sd24) zero_c = 1'b1;
		else sh = 6'(12'd30 - fe);
		q_c = 25'({2'b0, sig} >> sh);
		low_c = {2'b0, sig} << (6'd55 - sh);
		grd_c = low_c[54];
		stk_c = |low_c[53:0];
	end

	logic [63:0] x_s1;
	logic pass_s1, zero_s1, inf_s1, grd_s1, stk_s1, norm_s1;
	logic [24:0] q_s1;
	logic [7:0] fe_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (cfg.valid) keep_q <= cfg.data[0];
			if (adv) begin
				v_s1 <= in_ch.valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= x;
			pass_s1 <= pass;
			zero_s1 <= zero_c;
			inf_s1 <= inf_c;
			grd_s1 <= grd_c;
			stk_s1 <= stk_c;
			q_s1 <= q_c;
			norm_s1 <= !fe[11] && fe != 12'd0;
			fe_s1 <= fe[7:0];
		end
	end

	// stage 2 round
	logic [31:0] fb_c;
	logic [32:0] qr;
	always_comb begin
		qr = 33'(q_s1) + 33'(grd_s1 && (stk_s1 || q_s1[0]));
		if (norm_s1) qr = qr + ({25'd0, fe_s1 - 8'd1} << 23);
		if (zero_s1) fb_c = 32'd0;
		else if (inf_s1 || qr >= {1'b0, F32_INF}) fb_c = F32_INF;
		else fb_c = qr[31:0];
	end
	logic [63:0] x_s2;
	logic pass_s2;
	logic [31:0] fb_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2 <= x_s1;
			pass_s2 <= pass_s1;
			fb_s2 <= fb_c;
		end
	end

	// stage 3 repack
	logic [4:0] p;
	logic [63:0] mag, res_c;
	logic [22:0] fr;
	always_comb begin
		fr = fb_s2[22:0];
		p = 5'd0;
		for (int i = 0; i < 23; i++) if (fr[i]) p = 5'(i);
		if (fb_s2 >= F32_INF) mag = D64_INF;
		else if (fb_s2 == 32'd0) mag = 64'd0;
		else if (fb_s2[30:23] != 8'd0)
			mag = {1'b0, {3'b0, fb_s2[30:23]} + EXP_BIAS_DIFF, fr, 29'd0};
		else
			mag = {1'b0, {6'd0, p} + SUB_BIAS,
				52'(({29'd0, fr} & ~(52'd1 << p)) << (6'd52 - {1'b0, p}))};
		res_c = pass_s2 ? x_s2 : {x_s2[63], mag[62:0]};
	end
	logic [63:0] res_s3;
	always_ff @(posedge clk) begin
		if (adv) res_s3 <= res_c;
	end
	assign out_ch.valid = v_s3;
	assign out_ch.data = res_s3;
endmodule
`default_nettype wire
